// ----- sv/ptw_pkg.sv -----
package ptw_pkg;

  localparam int TABLE_FRAMES      = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int FRAME_W   = $clog2(TABLE_FRAMES);
  localparam int IDX_W     = $clog2(ENTRIES_PER_TABLE);
  localparam int ADDR_W    = FRAME_W + IDX_W;
  localparam int DEPTH     = TABLE_FRAMES * ENTRIES_PER_TABLE;
  localparam int NF_W      = (FRAME_W + 1 > 7) ? FRAME_W + 1 : 7;
  localparam int ENTRY_W   = 64;
  localparam int FLAG_W    = 12;
  localparam int CFG_FRAME_W = 6;
  localparam int FRAME_SHIFT = 12;

  typedef enum logic [1:0] {
    FAULT_OK    = 2'd0,
    FAULT_RANGE = 2'd1,
    FAULT_FULL  = 2'd2
  } fault_t;

  typedef enum logic [1:0] {
    REG_ROOT_FRAME = 2'd0,
    REG_FIRST_FREE = 2'd1,
    REG_FLAG_MASK  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_FRAME_W-1:0] root_frame;
    logic [CFG_FRAME_W-1:0] first_free;
    logic [FLAG_W-1:0]      flag_mask;
    logic                   nf_load;
  } cfg_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] leaf_entry;
    logic [FLAG_W-1:0]  top_flags;
    logic [FLAG_W-1:0]  dir_ptr_flags;
    logic [FLAG_W-1:0]  dir_flags;
    logic [FLAG_W-1:0]  leaf_flags;
    fault_t             fault;
  } res_t;

endpackage

// ----- sv/ptw_ram.sv -----
module ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

// ----- sv/ptw_ctrl.sv -----
module ptw_ctrl import ptw_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                start,
  input  logic                func,
  input  logic [47:0]         virt_addr,
  input  logic [51:0]         phys_addr,
  input  logic [FLAG_W-1:0]   page_flags,
  output logic                ready,
  output logic                done,
  output res_t                res
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_CHECK, S_WAIT, S_FILL} state_t;

  state_t              state;
  logic [ADDR_W-1:0]   clr_cnt;
  logic [1:0]          lvl;
  logic                func_q;
  logic [47:0]         va_q;
  logic [51:0]         pa_q;
  logic [FLAG_W-1:0]   pf_q;
  logic [FRAME_W-1:0]  frame;
  logic                frame_bad;
  logic [FRAME_W-1:0]  fill_frame;
  logic [IDX_W-1:0]    fill_cnt;
  logic [NF_W-1:0]     next_free;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_addr;
  logic [ENTRY_W-1:0]  mem_wdata;
  logic [ENTRY_W-1:0]  rd_entry;
  logic [IDX_W-1:0]    idx_cur;
  logic [ENTRY_W-1:0]  leaf_val;
  logic [ENTRY_W-1:0]  link_val;
  logic                nf_ok;
  logic                need_alloc;
  logic [FRAME_W-1:0]  ent_frame;
  logic                ent_bad;
  logic [FLAG_W-1:0]   ent_flags;

  ptw_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (rd_entry)
  );

  always_comb begin
    case (lvl)
      2'd0:    idx_cur = va_q[47:39];
      2'd1:    idx_cur = va_q[38:30];
      2'd2:    idx_cur = va_q[29:21];
      default: idx_cur = va_q[20:12];
    endcase
  end

  assign leaf_val   = {12'b0, pa_q} | ENTRY_W'(pf_q) | ENTRY_W'(3);
  assign link_val   = (ENTRY_W'(next_free[FRAME_W-1:0]) << FRAME_SHIFT) | ENTRY_W'(3);
  assign nf_ok      = next_free < NF_W'(TABLE_FRAMES);
  assign need_alloc = func_q && !rd_entry[0];
  assign ent_frame  = rd_entry[FRAME_SHIFT +: FRAME_W];
  assign ent_bad    = ((rd_entry >> (FRAME_SHIFT + FRAME_W)) != '0) ||
                      ({1'b0, ent_frame} >= (FRAME_W+1)'(TABLE_FRAMES));
  assign ent_flags  = rd_entry[FLAG_W-1:0] & cfg.flag_mask;
  assign ready      = (state == S_IDLE);

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = {frame, idx_cur};
    mem_wdata = leaf_val;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt;
        mem_wdata = '0;
      end
      S_CHECK: mem_we = func_q && (lvl == 2'd3) && !frame_bad;
      S_WAIT: begin
        mem_we    = need_alloc && nf_ok;
        mem_wdata = link_val;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_addr  = {fill_frame, fill_cnt};
        mem_wdata = '0;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      next_free <= NF_W'(1);
      done      <= 1'b0;
      lvl       <= '0;
      fill_cnt  <= '0;
    end else begin
      if (cfg.nf_load) next_free <= NF_W'(cfg.first_free);
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ADDR_W'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          // done is only ever raised on the way back to idle
          done <= 1'b0;
          if (start) begin
            func_q    <= func;
            va_q      <= virt_addr;
            pa_q      <= phys_addr;
            pf_q      <= page_flags;
            frame     <= FRAME_W'(cfg.root_frame);
            frame_bad <= int'(cfg.root_frame) >= TABLE_FRAMES;
            lvl       <= '0;
            res       <= '0;
            state     <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (frame_bad) begin
            res.fault <= FAULT_RANGE;
            done      <= 1'b1;
            state     <= S_IDLE;
          end else if (func_q && lvl == 2'd3) begin
            res.leaf_entry <= leaf_val;
            res.leaf_flags <= leaf_val[FLAG_W-1:0] & cfg.flag_mask;
            done           <= 1'b1;
            state          <= S_IDLE;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (lvl == 2'd3) begin
            res.leaf_entry <= rd_entry;
            res.leaf_flags <= ent_flags;
            done           <= 1'b1;
            state          <= S_IDLE;
          end else if (need_alloc && !nf_ok) begin
            res.fault <= FAULT_FULL;
            done      <= 1'b1;
            state     <= S_IDLE;
          end else if (need_alloc) begin
            fill_frame <= next_free[FRAME_W-1:0];
            next_free  <= next_free + 1'b1;
            fill_cnt   <= '0;
            state      <= S_FILL;
          end else begin
            case (lvl)
              2'd0:    res.top_flags     <= ent_flags;
              2'd1:    res.dir_ptr_flags <= ent_flags;
              default: res.dir_flags     <= ent_flags;
            endcase
            frame     <= ent_frame;
            frame_bad <= ent_bad;
            lvl       <= lvl + 1'b1;
            state     <= S_CHECK;
          end
        end
        S_FILL: begin
          fill_cnt <= fill_cnt + 1'b1;
          if (fill_cnt == IDX_W'(ENTRIES_PER_TABLE - 1)) begin
            // link is present|writeable, so its flags are just those two bits
            case (lvl)
              2'd0:    res.top_flags     <= FLAG_W'(3) & cfg.flag_mask;
              2'd1:    res.dir_ptr_flags <= FLAG_W'(3) & cfg.flag_mask;
              default: res.dir_flags     <= FLAG_W'(3) & cfg.flag_mask;
            endcase
            frame     <= fill_frame;
            frame_bad <= 1'b0;
            lvl       <= lvl + 1'b1;
            state     <= S_CHECK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !ready)
    else $error("walk ready during store clear");

  a_nf_mono: assert property (@(posedge clk) disable iff (rst)
    !cfg.nf_load |=> next_free >= $past(next_free))
    else $error("allocator went backwards");

  a_full_fault: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT && need_alloc && !nf_ok && lvl != 2'd3) |=>
      done && res.fault == FAULT_FULL)
    else $error("exhausted allocator not reported");

  a_fill_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_FILL |=> state == S_FILL || state == S_CHECK)
    else $error("fill left to wrong state");

endmodule

// ----- sv/four_level_page_table_walker_top.sv -----
// Walk: translate reads one table entry per level; map also writes the leaf and
//   zero-fills each table frame it allocates (512-entry zero fill).
// Flow: one walk at a time; the next beat is taken the cycle after the result
//   beat is taken.
// Reset: synchronous; the table store is then cleared, one entry a cycle, for all
//   TABLE_FRAMES*512 entries (32768) before the first beat is accepted.
module four_level_page_table_walker_top import ptw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [11:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              func,
  input  logic [47:0]       virt_addr,
  input  logic [51:0]       phys_addr,
  input  logic [11:0]       page_flags,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [63:0]       leaf_entry,
  output logic [11:0]       top_flags,
  output logic [11:0]       dir_ptr_flags,
  output logic [11:0]       dir_flags,
  output logic [11:0]       leaf_flags,
  output logic [1:0]        fault
);

  cfg_t cfg;
  logic ready;
  logic done;
  logic start;
  res_t res;
  res_t res_q;

  // done marks a result on its way into res_q; hold the input until it is taken
  assign in_stall    = !ready || out_valid || done;
  assign start       = in_valid && !in_stall;

  // allocator reload happens in the cycle after the register write, so it sees the new value
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.root_frame <= '0;
      cfg.first_free <= CFG_FRAME_W'(1);
      cfg.flag_mask  <= '1;
      cfg.nf_load    <= 1'b0;
    end else begin
      cfg.nf_load <= cfg_we && (cfg_idx == REG_FIRST_FREE);
      if (cfg_we) begin
        case (cfg_idx)
          REG_ROOT_FRAME: cfg.root_frame <= cfg_wdata[CFG_FRAME_W-1:0];
          REG_FIRST_FREE: cfg.first_free <= cfg_wdata[CFG_FRAME_W-1:0];
          REG_FLAG_MASK:  cfg.flag_mask  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  ptw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .start      (start),
    .func       (func),
    .virt_addr  (virt_addr),
    .phys_addr  (phys_addr),
    .page_flags (page_flags),
    .ready      (ready),
    .done       (done),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) res_q <= res;
  end

  assign leaf_entry    = res_q.leaf_entry;
  assign top_flags     = res_q.top_flags;
  assign dir_ptr_flags = res_q.dir_ptr_flags;
  assign dir_flags     = res_q.dir_flags;
  assign leaf_flags    = res_q.leaf_flags;
  assign fault         = res_q.fault;

endmodule
